// ===== rtl/core/fcq_pkg.sv =====
// shared types and constants of the frame/command pending queue
`timescale 1ns / 1ps
`default_nettype none

package fcq_pkg;

	localparam int MAX_FRAMES_LIMIT = 8;
	localparam int COMMAND_HEADROOM = 8;
	localparam int QUEUE_DEPTH      = 32;

	localparam int IDX_W   = $clog2(QUEUE_DEPTH);
	localparam int OCC_W   = $clog2(QUEUE_DEPTH + 1);
	localparam int CNT_W   = $clog2(QUEUE_DEPTH + MAX_FRAMES_LIMIT + COMMAND_HEADROOM + 16);
	localparam int MF_W    = 4;
	localparam int SEQ_W   = 64;
	localparam int PAY_W   = 16;
	localparam int DATA_W  = 32;
	localparam int PADDR_W = 3;

	localparam logic [MF_W-1:0] MAX_FRAMES_RESET = MF_W'(3);
	localparam logic            REG_MAX_FRAMES   = 1'b0;

	localparam logic KIND_FRAME   = 1'b0;
	localparam logic KIND_COMMAND = 1'b1;

	typedef enum logic [1:0] {
		FUNC_FRAME   = 2'd0,
		FUNC_COMMAND = 2'd1,
		FUNC_TAKE    = 2'd2,
		FUNC_STOP    = 2'd3
	} func_t;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_STOPPED = 2'd1,
		ST_FULL    = 2'd2,
		ST_EMPTY   = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		RES_PLAIN  = 2'd0,
		RES_DROP   = 2'd1,
		RES_TAKE   = 2'd2,
		RES_ASSIGN = 2'd3
	} res_sel_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_EXEC,
		S_APPEND
	} ctrl_state_t;

	typedef struct packed {
		logic     latch;
		logic     out_load;
		res_sel_t res_sel;
		status_t  status;
		logic     remove_newest;
		logic     remove_head;
		logic     append;
		logic     set_halt;
	} dp_cmd_t;

	typedef struct packed {
		func_t func;
		logic  halted;
		logic  frames_at_lim;
		logic  occ_full;
		logic  cmd_full;
		logic  empty;
		logic  out_free;
	} dp_stat_t;

endpackage

`default_nettype wire

// ===== rtl/core/fcq_ctrl.sv =====
// controller state machine of the pending queue
`timescale 1ns / 1ps
`default_nettype none

module fcq_ctrl
	import fcq_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     in_valid,
	output logic          in_ready,
	input  wire dp_stat_t stat,
	output dp_cmd_t       cmd
);

	ctrl_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		in_ready = 1'b0;
		cmd      = '0;
		cmd.res_sel = RES_PLAIN;
		cmd.status  = ST_OK;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.latch = 1'b1;
					state_d   = S_EXEC;
				end
			end
			S_EXEC: begin
				if (stat.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
					case (stat.func)
						FUNC_FRAME: begin
							if (stat.halted) begin
								cmd.status = ST_STOPPED;
							end else if (stat.frames_at_lim) begin
								cmd.res_sel       = RES_DROP;
								cmd.remove_newest = 1'b1;
								state_d           = S_APPEND;
							end else if (stat.occ_full) begin
								cmd.status = ST_FULL;
							end else begin
								cmd.res_sel = RES_ASSIGN;
								cmd.append  = 1'b1;
							end
						end
						FUNC_COMMAND: begin
							if (stat.halted) begin
								cmd.status = ST_STOPPED;
							end else if (stat.cmd_full) begin
								cmd.status = ST_FULL;
							end else begin
								cmd.res_sel = RES_ASSIGN;
								cmd.append  = 1'b1;
							end
						end
						FUNC_TAKE: begin
							if (stat.empty) begin
								cmd.status = ST_EMPTY;
							end else begin
								cmd.res_sel     = RES_TAKE;
								cmd.remove_head = 1'b1;
							end
						end
						default: begin
							cmd.set_halt = 1'b1;
						end
					endcase
				end
			end
			S_APPEND: begin
				if (stat.out_free) begin
					cmd.out_load = 1'b1;
					cmd.res_sel  = RES_ASSIGN;
					cmd.append   = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

`default_nettype wire

// ===== rtl/core/fcq_datapath.sv =====
// queue storage, counters and result register of the pending queue
`timescale 1ns / 1ps
`default_nettype none

module fcq_datapath
	import fcq_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic [MF_W-1:0]  max_frames,
	input  wire logic [1:0]       func,
	input  wire logic [PAY_W-1:0] payload,
	input  wire dp_cmd_t          cmd,
	output dp_stat_t              stat,
	output logic                  out_valid,
	input  wire logic             out_ready,
	output logic [1:0]            status,
	output logic [SEQ_W-1:0]      seq_number,
	output logic                  entry_is_command,
	output logic [PAY_W-1:0]      payload_out,
	output logic                  dropped,
	output logic                  last
);

	logic             slot_kind_q [QUEUE_DEPTH];
	logic [SEQ_W-1:0] slot_seq_q  [QUEUE_DEPTH];
	logic [PAY_W-1:0] slot_pay_q  [QUEUE_DEPTH];

	logic [OCC_W-1:0] occ_q;
	logic [OCC_W-1:0] frames_q;
	logic [IDX_W-1:0] newest_q;
	logic [SEQ_W-1:0] next_seq_q;
	logic             halted_q;

	func_t            func_q;
	logic [PAY_W-1:0] payload_q;

	logic             out_valid_q;
	status_t          out_status_q;
	logic [SEQ_W-1:0] out_seq_q;
	logic             out_cmd_q;
	logic [PAY_W-1:0] out_pay_q;
	logic             out_drop_q;
	logic             out_last_q;

	logic [CNT_W-1:0] lim;
	logic [CNT_W-1:0] cap;
	logic [CNT_W-1:0] cap_raw;
	logic [IDX_W-1:0] remove_pos;
	logic             shift_en;
	logic [IDX_W-1:0] append_idx;
	logic             append_kind;

	// effective frame limit, clamped to 1..MAX_FRAMES_LIMIT
	always_comb begin
		if (max_frames == '0) begin
			lim = CNT_W'(1);
		end else if (CNT_W'(max_frames) > CNT_W'(MAX_FRAMES_LIMIT)) begin
			lim = CNT_W'(MAX_FRAMES_LIMIT);
		end else begin
			lim = CNT_W'(max_frames);
		end
		cap_raw = lim + CNT_W'(COMMAND_HEADROOM);
		cap     = (cap_raw > CNT_W'(QUEUE_DEPTH)) ? CNT_W'(QUEUE_DEPTH) : cap_raw;
	end

	assign stat.func          = func_q;
	assign stat.halted        = halted_q;
	assign stat.frames_at_lim = CNT_W'(frames_q) >= lim;
	assign stat.occ_full      = CNT_W'(occ_q) >= CNT_W'(QUEUE_DEPTH);
	assign stat.cmd_full      = CNT_W'(occ_q) >= cap;
	assign stat.empty         = occ_q == '0;
	assign stat.out_free      = !out_valid_q || out_ready;

	assign shift_en    = cmd.remove_newest || cmd.remove_head;
	assign remove_pos  = cmd.remove_head ? '0 : newest_q;
	assign append_idx  = occ_q[IDX_W-1:0];
	assign append_kind = (func_q == FUNC_COMMAND) ? KIND_COMMAND : KIND_FRAME;

	// item register
	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			func_q    <= func_t'(func);
			payload_q <= payload;
		end
	end

	// slots: append at the tail, collapse toward the head on a removal
	for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_slot
		always_ff @(posedge clk) begin
			if (cmd.append && append_idx == IDX_W'(i)) begin
				slot_kind_q[i] <= append_kind;
				slot_seq_q[i]  <= next_seq_q;
				slot_pay_q[i]  <= payload_q;
			end else if (shift_en && remove_pos <= IDX_W'(i)) begin
				if (i < QUEUE_DEPTH - 1) begin
					slot_kind_q[i] <= slot_kind_q[(i + 1) % QUEUE_DEPTH];
					slot_seq_q[i]  <= slot_seq_q[(i + 1) % QUEUE_DEPTH];
					slot_pay_q[i]  <= slot_pay_q[(i + 1) % QUEUE_DEPTH];
				end
			end
		end
	end

	// counters; the newest frame position is tracked, never searched
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q      <= '0;
			frames_q   <= '0;
			newest_q   <= '0;
			next_seq_q <= SEQ_W'(1);
			halted_q   <= 1'b0;
		end else begin
			if (cmd.set_halt) begin
				halted_q <= 1'b1;
			end
			if (cmd.append) begin
				occ_q      <= occ_q + OCC_W'(1);
				next_seq_q <= next_seq_q + SEQ_W'(1);
				if (append_kind == KIND_FRAME) begin
					frames_q <= frames_q + OCC_W'(1);
					newest_q <= append_idx;
				end
			end else if (cmd.remove_newest) begin
				occ_q    <= occ_q - OCC_W'(1);
				frames_q <= frames_q - OCC_W'(1);
			end else if (cmd.remove_head) begin
				occ_q    <= occ_q - OCC_W'(1);
				newest_q <= newest_q - IDX_W'(1);
				if (slot_kind_q[0] == KIND_FRAME) begin
					frames_q <= frames_q - OCC_W'(1);
				end
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_status_q <= cmd.status;
			out_drop_q   <= cmd.res_sel == RES_DROP;
			out_last_q   <= cmd.res_sel != RES_DROP;
			case (cmd.res_sel)
				RES_DROP: begin
					out_seq_q <= slot_seq_q[newest_q];
					out_cmd_q <= 1'b0;
					out_pay_q <= slot_pay_q[newest_q];
				end
				RES_TAKE: begin
					out_seq_q <= slot_seq_q[0];
					out_cmd_q <= slot_kind_q[0];
					out_pay_q <= slot_pay_q[0];
				end
				RES_ASSIGN: begin
					out_seq_q <= next_seq_q;
					out_cmd_q <= 1'b0;
					out_pay_q <= '0;
				end
				default: begin
					out_seq_q <= '0;
					out_cmd_q <= 1'b0;
					out_pay_q <= '0;
				end
			endcase
		end
	end

	assign out_valid        = out_valid_q;
	assign status           = out_status_q;
	assign seq_number       = out_seq_q;
	assign entry_is_command = out_cmd_q;
	assign payload_out      = out_pay_q;
	assign dropped          = out_drop_q;
	assign last             = out_last_q;

endmodule

`default_nettype wire

// ===== rtl/core/frame_command_queue_newest_drop_core.sv =====
// top level of the frame/command pending queue with newest-frame replacement
`timescale 1ns / 1ps
`default_nettype none

// Ordered pending queue of frame and command entries. Each accepted submit
// gets the next 64-bit sequence number (starting at 1, wrapping). A frame
// submit when max_frames (clamped to 1..8) frames are already pending first
// returns the newest pending frame as a dropped result (dropped=1, last=0),
// then the new frame's sequence (last=1). Commands are refused with status 2
// once the entry count reaches clamped max_frames + 8. A take pops the head
// entry; status 3 when empty. A stop makes all later submits fail with
// status 1, takes still drain. An item is accepted, then executed; a frame
// that replaces the newest one also takes an append step. The controller
// handles one item at a time and each result waits for the single output
// register to be free. The newest frame position is tracked in a register,
// so no search is needed; max_frames: register port address 0, reset value 3.
module frame_command_queue_newest_drop_core
	import fcq_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	// register port
	input  wire logic               psel,
	input  wire logic               penable,
	input  wire logic               pwrite,
	input  wire logic [PADDR_W-1:0] paddr,
	input  wire logic [DATA_W-1:0]  pwdata,
	output logic [DATA_W-1:0]       prdata,
	output logic                    pready,
	// request channel
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic [1:0]         func,
	input  wire logic [PAY_W-1:0]   payload,
	// result channel
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic [1:0]              status,
	output logic [SEQ_W-1:0]        seq_number,
	output logic                    entry_is_command,
	output logic [PAY_W-1:0]        payload_out,
	output logic                    dropped,
	output logic                    last
);

	logic [MF_W-1:0] max_frames_q;
	logic            cfg_sel;
	dp_cmd_t         cmd;
	dp_stat_t        stat;

	// register decode: one word-aligned register
	assign pready  = 1'b1;
	assign cfg_sel = paddr[2] == REG_MAX_FRAMES;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_frames_q <= MAX_FRAMES_RESET;
		end else if (psel && penable && pwrite && cfg_sel) begin
			max_frames_q <= pwdata[MF_W-1:0];
		end
	end

	// read returns the register, zero elsewhere
	assign prdata = cfg_sel ? DATA_W'(max_frames_q) : '0;

	// controller decides, datapath executes one command per cycle
	fcq_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	fcq_datapath u_datapath (
		.clk              (clk),
		.arst_n           (arst_n),
		.max_frames       (max_frames_q),
		.func             (func),
		.payload          (payload),
		.cmd              (cmd),
		.stat             (stat),
		.out_valid        (out_valid),
		.out_ready        (out_ready),
		.status           (status),
		.seq_number       (seq_number),
		.entry_is_command (entry_is_command),
		.payload_out      (payload_out),
		.dropped          (dropped),
		.last             (last)
	);

endmodule

`default_nettype wire

// ===== rtl/core/fcq_checker.sv =====
// port-level checks of the pending queue and their binding
`timescale 1ns / 1ps
`default_nettype none

module fcq_checker
	import fcq_pkg::*;
(
	input wire logic             clk,
	input wire logic             arst_n,
	input wire logic             in_valid,
	input wire logic             in_ready,
	input wire logic             out_valid,
	input wire logic             out_ready,
	input wire logic [1:0]       status,
	input wire logic [SEQ_W-1:0] seq_number,
	input wire logic             dropped,
	input wire logic             last
);

	// one item at a time: no transfer in the cycle after an accepted one
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("request accepted back to back");

	// a stalled result holds
	a_result_holds: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(seq_number) && $stable(last))
		else $error("stalled result changed");

	// a replaced frame is reported as a success and is never the final result
	a_drop_shape: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && dropped |-> !last && status == ST_OK)
		else $error("malformed drop result");

	// a refused or empty result carries no sequence
	a_refusal_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == ST_STOPPED || status == ST_FULL || status == ST_EMPTY)
		|-> seq_number == '0 && last)
		else $error("refusal carries a sequence");

endmodule

bind frame_command_queue_newest_drop_core fcq_checker u_fcq_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (in_valid),
	.in_ready   (in_ready),
	.out_valid  (out_valid),
	.out_ready  (out_ready),
	.status     (status),
	.seq_number (seq_number),
	.dropped    (dropped),
	.last       (last)
);

`default_nettype wire
